// ----- hw/rtl/pidft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidft_pkg
// Shared types and codes for the paired-id forwarding table bank.
// ----------------------------------------------------------------------------
package pidft_pkg;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_PARTNER = 2'd1;
  localparam logic [1:0] OP_LINK    = 2'd2;
  localparam logic [1:0] OP_PEER    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [7:0]  link;
    logic [15:0] ident_a;
    logic [15:0] ident_b;
    logic [7:0]  peer_a;
    logic [7:0]  peer_b;
  } row_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
  } sts_t;

endpackage

// ----- hw/rtl/pidft_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidft_req_if / pidft_rsp_if
// Request and response channels of the forwarding table bank.
// ----------------------------------------------------------------------------
interface pidft_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        side;
  logic [1:0]  module_req;
  logic [7:0]  link_id;
  logic [15:0] ident;
  logic [7:0]  peer;

  modport source (output valid, opcode, side, module_req, link_id, ident, peer,
                  input ready);
  modport sink (input valid, opcode, side, module_req, link_id, ident, peer,
                output ready);
endinterface

interface pidft_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_ident;
  logic [7:0]  out_link;
  logic [7:0]  out_peer;

  modport source (output valid, status, out_ident, out_link, out_peer,
                  input ready);
  modport sink (input valid, status, out_ident, out_link, out_peer,
                output ready);
endinterface

// ----- hw/rtl/paired_id_forwarding_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_id_forwarding_table
// Bank of base-station and relay forwarding tables holding paired ids.
// ----------------------------------------------------------------------------
// Usage:
//   req  - request word: opcode, side, module_req, link_id, ident, peer.
//   rsp  - one response word per request: status, out_ident, out_link,
//          out_peer. Both channels transfer on valid and ready high.
//   One request is in flight at a time. After acceptance the selected
//   table's rows are read one per cycle from the row memory, stopping at
//   the first match; the single read port sets the pace. Each request
//   runs through the scan and done states before its response is loaded,
//   and the next request is taken only after that response is loaded, so
//   a new request word is not accepted while the last one is in progress.
//   Reset clears all table fill counts at once; no clearing pass is run.
//   When the receiver stalls, the response holds in the output register;
//   the next request is still accepted and processed, and it waits for
//   the register before retiring.
// ----------------------------------------------------------------------------
module paired_id_forwarding_table #(
  parameter int BASE_TABLES  = 4,
  parameter int RELAY_TABLES = 4,
  parameter int ENTRIES      = 8
) (
  input  logic         clk,
  input  logic         rst,
  pidft_req_if.sink    req,
  pidft_rsp_if.source  rsp
);

  pidft_pkg::cmd_t cmd;
  pidft_pkg::sts_t sts;

  pidft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidft_datapath #(
    .BASE_TABLES  (BASE_TABLES),
    .RELAY_TABLES (RELAY_TABLES),
    .ENTRIES      (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (req.opcode),
    .side       (req.side),
    .module_req (req.module_req),
    .link_id    (req.link_id),
    .ident      (req.ident),
    .peer       (req.peer),
    .status     (rsp.status),
    .out_ident  (rsp.out_ident),
    .out_link   (rsp.out_link),
    .out_peer   (rsp.out_peer)
  );

endmodule

// ----- hw/rtl/pidft_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidft_ctrl
// Sequencer: accept a request word, step the table scan, then retire the
// result into the output register once it is free.
// ----------------------------------------------------------------------------
module pidft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pidft_pkg::sts_t   sts,
  output pidft_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;
  state_t state_next;

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = (state == S_IDLE) && in_valid;
  assign cmd.scan   = (state == S_SCAN);
  assign cmd.finish = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (sts.hit || sts.scan_end) state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result retired into occupied output register");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while busy");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule

// ----- hw/rtl/pidft_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidft_datapath
// Request registers, per-table fill counters, row memory with a registered
// read port, scan compare and result formation.
// ----------------------------------------------------------------------------
module pidft_datapath #(
  parameter int BASE_TABLES  = 4,
  parameter int RELAY_TABLES = 4,
  parameter int ENTRIES      = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pidft_pkg::cmd_t   cmd,
  output pidft_pkg::sts_t   sts,
  input  logic [1:0]        opcode,
  input  logic              side,
  input  logic [1:0]        module_req,
  input  logic [7:0]        link_id,
  input  logic [15:0]       ident,
  input  logic [7:0]        peer,
  output logic [1:0]        status,
  output logic [15:0]       out_ident,
  output logic [7:0]        out_link,
  output logic [7:0]        out_peer
);

  localparam int NT    = BASE_TABLES + RELAY_TABLES;
  localparam int NROWS = NT * ENTRIES;
  localparam int TW    = (NT > 1) ? $clog2(NT) : 1;
  localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);

  pidft_pkg::row_t mem [NROWS];
  pidft_pkg::row_t rdata;

  logic [CW-1:0] fill [NT];

  logic [1:0]    op_q;
  logic          side_q;
  logic [7:0]    link_q;
  logic [15:0]   ident_q;
  logic [7:0]    peer_q;
  logic          tbl_ok;
  logic [TW-1:0] tbl;
  logic [RW-1:0] row_base;
  logic [CW-1:0] rd_idx;
  logic [IW-1:0] pend_idx;
  logic          pend;
  logic          found;

  logic          sel_side;
  logic          ok_next;
  logic [TW-1:0] tbl_next;
  logic [CW-1:0] cur_fill;
  logic          match;
  logic          scan_hit;
  logic          issue;
  logic [7:0]    pv;
  logic          placed;
  logic          can_append;
  logic          we;
  logic [RW-1:0] waddr;
  pidft_pkg::row_t wrow;
  logic          hit_a;
  logic          hit_b;
  logic [15:0]   part_ident;
  logic [7:0]    part_peer;

  always_comb begin
    sel_side = (opcode == pidft_pkg::OP_PEER) ? 1'b0 : side;
    ok_next  = sel_side ? ({3'b000, module_req} < 5'(BASE_TABLES))
                        : ({3'b000, module_req} < 5'(RELAY_TABLES));
    if (!ok_next) begin
      tbl_next = '0;
    end else if (sel_side) begin
      tbl_next = TW'(module_req);
    end else begin
      tbl_next = TW'(5'(BASE_TABLES) + {3'b000, module_req});
    end
  end

  assign cur_fill = tbl_ok ? fill[tbl] : '0;
  assign match    = (op_q == pidft_pkg::OP_LINK)
                    ? ((rdata.ident_a == ident_q) || (rdata.ident_b == ident_q))
                    : (rdata.link == link_q);
  assign scan_hit = pend && match;
  assign issue    = cmd.scan && !scan_hit && (rd_idx < cur_fill);
  assign sts.hit      = scan_hit;
  assign sts.scan_end = !scan_hit && (rd_idx >= cur_fill);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= opcode;
      side_q   <= side;
      link_q   <= link_id;
      ident_q  <= ident;
      peer_q   <= peer;
      tbl_ok   <= ok_next;
      tbl      <= tbl_next;
      row_base <= RW'(32'(tbl_next) * ENTRIES);
      rd_idx   <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      found <= scan_hit;
      if (issue) begin
        rd_idx   <= rd_idx + CW'(1);
        pend_idx <= rd_idx[IW-1:0];
        pend     <= 1'b1;
      end else if (!scan_hit) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= mem[row_base + RW'(rd_idx)];
    end
  end

  always_comb begin
    pv         = side_q ? 8'h00 : peer_q;
    placed     = found && ((rdata.ident_a == 16'h0000) || (rdata.ident_b == 16'h0000));
    can_append = cur_fill < CW'(ENTRIES);
    wrow       = rdata;
    waddr      = row_base + RW'(pend_idx);
    we         = 1'b0;
    if (cmd.finish && tbl_ok && (op_q == pidft_pkg::OP_ADD)) begin
      if (placed) begin
        we = 1'b1;
        if (rdata.ident_a == 16'h0000) begin
          wrow.ident_a = ident_q;
          wrow.peer_a  = pv;
        end else begin
          wrow.ident_b = ident_q;
          wrow.peer_b  = pv;
        end
      end else if (can_append) begin
        we           = 1'b1;
        waddr        = row_base + RW'(cur_fill);
        wrow.link    = link_q;
        wrow.ident_a = ident_q;
        wrow.ident_b = 16'h0000;
        wrow.peer_a  = pv;
        wrow.peer_b  = 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wrow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        fill[i] <= '0;
      end
    end else if (we && !placed) begin
      fill[tbl] <= cur_fill + CW'(1);
    end
  end

  always_comb begin
    hit_a      = rdata.ident_a == ident_q;
    hit_b      = rdata.ident_b == ident_q;
    part_ident = hit_b ? rdata.ident_a : (hit_a ? rdata.ident_b : 16'h0000);
    part_peer  = (rdata.peer_b == peer_q) ? rdata.peer_a : rdata.peer_b;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status    <= pidft_pkg::ST_MISS;
      out_ident <= 16'h0000;
      out_link  <= 8'h00;
      out_peer  <= 8'h00;
      if (tbl_ok) begin
        case (op_q)
          pidft_pkg::OP_ADD: begin
            status <= (placed || can_append) ? pidft_pkg::ST_OK : pidft_pkg::ST_FULL;
          end
          pidft_pkg::OP_PARTNER: begin
            if (found && (hit_a || hit_b) && (part_ident != 16'h0000)) begin
              status    <= pidft_pkg::ST_OK;
              out_ident <= part_ident;
            end
          end
          pidft_pkg::OP_LINK: begin
            if (found) begin
              status   <= pidft_pkg::ST_OK;
              out_link <= rdata.link;
            end
          end
          pidft_pkg::OP_PEER: begin
            if (found && ((rdata.peer_a == peer_q) || (rdata.peer_b == peer_q))) begin
              status   <= pidft_pkg::ST_OK;
              out_peer <= part_peer;
            end
          end
          default: status <= pidft_pkg::ST_MISS;
        endcase
      end
    end
  end

endmodule

// ----- sim/paired_id_forwarding_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_id_forwarding_table_test
// Self-checking bench for the paired-id forwarding table bank. A shadow copy
// of every table is updated as each request word is accepted. Each response
// word is checked against the oldest predicted response. Directed words
// cover empty tables, slot pairing, duplicate identifiers, empty slots and
// a full table. Random traffic follows, mostly drawn from stored rows, under
// random stalls, one long receiver hold-off and one drained sender pause.
// ----------------------------------------------------------------------------
module paired_id_forwarding_table_test;

  localparam int BASE_TABLES  = 4;
  localparam int RELAY_TABLES = 4;
  localparam int ENTRIES      = 8;
  localparam int NUM_TABLES   = BASE_TABLES + RELAY_TABLES;
  localparam int QUIET_LIMIT  = 2000;

  localparam logic SIDE_RELAY = 1'b0;
  localparam logic SIDE_BASE  = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        side;
    logic [1:0]  module_req;
    logic [7:0]  link_id;
    logic [15:0] ident;
    logic [7:0]  peer;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_ident;
    logic [7:0]  out_link;
    logic [7:0]  out_peer;
  } rsp_word_t;

  logic clk;
  logic rst;

  pidft_req_if req_ch ();
  pidft_rsp_if rsp_ch ();

  paired_id_forwarding_table #(
    .BASE_TABLES (BASE_TABLES),
    .RELAY_TABLES(RELAY_TABLES),
    .ENTRIES     (ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  pidft_pkg::row_t shadow_rows [NUM_TABLES][ENTRIES];
  int          shadow_fill [NUM_TABLES];
  rsp_word_t   pending_rsp [$];
  logic [7:0]  link_pool [6];
  int          mismatches;
  bit          idle_on;
  int          hold_len;

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int table_of(input logic side, input logic [1:0] module_req);
    if (side == SIDE_BASE) begin
      if (module_req >= BASE_TABLES) return -1;
      return int'(module_req);
    end
    if (module_req >= RELAY_TABLES) return -1;
    return BASE_TABLES + int'(module_req);
  endfunction

  function automatic int first_row(input int t, input logic [7:0] link);
    for (int i = 0; i < shadow_fill[t]; i++) begin
      if (shadow_rows[t][i].link == link) return i;
    end
    return -1;
  endfunction

  function automatic rsp_word_t apply_request(input req_word_t w);
    rsp_word_t       res;
    pidft_pkg::row_t row;
    int              t;
    int              r;
    logic [7:0]      pv;
    logic            hit;
    logic [15:0]     vi;
    logic [7:0]      vp;
    res = '0;
    res.status = pidft_pkg::ST_MISS;
    t = table_of((w.opcode == pidft_pkg::OP_PEER) ? SIDE_RELAY : w.side, w.module_req);
    if (t < 0) return res;
    case (w.opcode)
      pidft_pkg::OP_ADD: begin
        pv = (w.side == SIDE_BASE) ? 8'h00 : w.peer;
        r = first_row(t, w.link_id);
        hit = 1'b0;
        if (r >= 0) begin
          if (shadow_rows[t][r].ident_a == '0) begin
            shadow_rows[t][r].ident_a = w.ident;
            shadow_rows[t][r].peer_a  = pv;
            hit = 1'b1;
          end else if (shadow_rows[t][r].ident_b == '0) begin
            shadow_rows[t][r].ident_b = w.ident;
            shadow_rows[t][r].peer_b  = pv;
            hit = 1'b1;
          end
        end
        if (hit) begin
          res.status = pidft_pkg::ST_OK;
        end else if (shadow_fill[t] < ENTRIES) begin
          row.link    = w.link_id;
          row.ident_a = w.ident;
          row.ident_b = '0;
          row.peer_a  = pv;
          row.peer_b  = '0;
          shadow_rows[t][shadow_fill[t]] = row;
          shadow_fill[t]++;
          res.status = pidft_pkg::ST_OK;
        end else begin
          res.status = pidft_pkg::ST_FULL;
        end
      end
      pidft_pkg::OP_PARTNER: begin
        r = first_row(t, w.link_id);
        if (r >= 0) begin
          row = shadow_rows[t][r];
          hit = 1'b0;
          vi = '0;
          if (row.ident_a == w.ident) begin
            vi = row.ident_b;
            hit = 1'b1;
          end
          if (row.ident_b == w.ident) begin
            vi = row.ident_a;
            hit = 1'b1;
          end
          if (hit && vi != '0) begin
            res.status    = pidft_pkg::ST_OK;
            res.out_ident = vi;
          end
        end
      end
      pidft_pkg::OP_LINK: begin
        for (int i = 0; i < shadow_fill[t]; i++) begin
          if (shadow_rows[t][i].ident_a == w.ident || shadow_rows[t][i].ident_b == w.ident)
          begin
            res.status   = pidft_pkg::ST_OK;
            res.out_link = shadow_rows[t][i].link;
            break;
          end
        end
      end
      default: begin
        r = first_row(t, w.link_id);
        if (r >= 0) begin
          row = shadow_rows[t][r];
          hit = 1'b0;
          vp = '0;
          if (row.peer_a == w.peer) begin
            vp = row.peer_b;
            hit = 1'b1;
          end
          if (row.peer_b == w.peer) begin
            vp = row.peer_a;
            hit = 1'b1;
          end
          if (hit) begin
            res.status   = pidft_pkg::ST_OK;
            res.out_peer = vp;
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // check each accepted response word against the oldest prediction
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response word with none pending", 16'(rsp_ch.status), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 16'(rsp_ch.status), 16'(want.status));
        if (rsp_ch.out_ident !== want.out_ident)
          report_mismatch("out_ident", rsp_ch.out_ident, want.out_ident);
        if (rsp_ch.out_link !== want.out_link)
          report_mismatch("out_link", 16'(rsp_ch.out_link), 16'(want.out_link));
        if (rsp_ch.out_peer !== want.out_peer)
          report_mismatch("out_peer", 16'(rsp_ch.out_peer), 16'(want.out_peer));
      end
    end
  end

  // response side: random stall bursts, plus a long hold when requested
  initial begin : receiver
    int stall_cnt;
    stall_cnt = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        stall_cnt = hold_len;
        hold_len = 0;
      end else if (stall_cnt == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(1, 4);
      end
      if (stall_cnt > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_cnt--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("paired_id_forwarding_table_test: done, errors");
    $finish;
  end

  // called and returning at a falling edge
  task automatic send_word(input logic [1:0] opcode, input logic side,
                           input logic [1:0] module_req, input logic [7:0] link_id,
                           input logic [15:0] ident, input logic [7:0] peer);
    req_word_t w;
    w = '{opcode, side, module_req, link_id, ident, peer};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= w.opcode;
    req_ch.side       <= w.side;
    req_ch.module_req <= w.module_req;
    req_ch.link_id    <= w.link_id;
    req_ch.ident      <= w.ident;
    req_ch.peer       <= w.peer;
    do @(posedge clk); while (!req_ch.ready);
    pending_rsp.push_back(apply_request(w));
    @(negedge clk);
  endtask

  task automatic send_random_word();
    logic [1:0]  op;
    logic        sd;
    logic [1:0]  md;
    logic [7:0]  lk;
    logic [15:0] id;
    logic [7:0]  pr;
    int          t;
    int          r;
    case ($urandom_range(0, 9)) inside
      [0:3]:   op = pidft_pkg::OP_ADD;
      [4:5]:   op = pidft_pkg::OP_PARTNER;
      [6:7]:   op = pidft_pkg::OP_LINK;
      default: op = pidft_pkg::OP_PEER;
    endcase
    sd = 1'($urandom);
    md = 2'($urandom);
    lk = ($urandom_range(0, 4) != 0) ? link_pool[$urandom_range(0, 5)] : 8'($urandom);
    id = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
    pr = 8'($urandom);
    t = table_of((op == pidft_pkg::OP_PEER) ? SIDE_RELAY : sd, md);
    // draw most keys from stored rows so lookups hit
    if (t >= 0 && shadow_fill[t] > 0 && $urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, shadow_fill[t] - 1);
      lk = shadow_rows[t][r].link;
      if ($urandom_range(0, 3) != 0)
        id = $urandom_range(0, 1) ? shadow_rows[t][r].ident_a : shadow_rows[t][r].ident_b;
      if ($urandom_range(0, 3) != 0)
        pr = $urandom_range(0, 1) ? shadow_rows[t][r].peer_a : shadow_rows[t][r].peer_b;
    end
    send_word(op, sd, md, lk, id, pr);
  endtask

  task automatic test_empty_tables();
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd0, 8'h00, 16'h0000, 8'h00);
    send_word(pidft_pkg::OP_LINK, SIDE_BASE, 2'd3, 8'hFF, 16'h0000, 8'hFF);
    send_word(pidft_pkg::OP_PEER, SIDE_BASE, 2'd0, 8'h00, 16'hFFFF, 8'h00);
  endtask

  task automatic test_pairing();
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd3, 8'h00, 16'hFFFF, 8'hFF);
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd3, 8'h00, 16'h0001, 8'h00);
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd3, 8'h00, 16'hFFFF, 8'h00);
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd3, 8'h00, 16'h0001, 8'h00);
    // peer lookup ignores side
    send_word(pidft_pkg::OP_PEER, SIDE_BASE, 2'd3, 8'h00, 16'h0000, 8'hFF);
    // full pair: append a second row with the same link
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd3, 8'h00, 16'h00AA, 8'h11);
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd3, 8'h00, 16'h00AA, 8'h00);
  endtask

  task automatic test_special_slots();
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd2, 8'hFF, 16'h0000, 8'h55);
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd2, 8'hFF, 16'hBEEF, 8'hAA);
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd2, 8'hFF, 16'hBEEF, 8'h00);
    send_word(pidft_pkg::OP_ADD, SIDE_RELAY, 2'd2, 8'hFF, 16'hBEEF, 8'hAA);
    send_word(pidft_pkg::OP_PARTNER, SIDE_RELAY, 2'd2, 8'hFF, 16'hBEEF, 8'h00);
    send_word(pidft_pkg::OP_PEER, SIDE_RELAY, 2'd2, 8'hFF, 16'h0000, 8'hAA);
    send_word(pidft_pkg::OP_LINK, SIDE_RELAY, 2'd2, 8'h00, 16'h8000, 8'h00);
    send_word(pidft_pkg::OP_ADD, SIDE_BASE, 2'd0, 8'h80, 16'h4000, 8'hFF);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < ENTRIES; i++)
      send_word(pidft_pkg::OP_ADD, SIDE_BASE, 2'd1, 8'(i + 1), 16'(16'h1000 + i), 8'h00);
    send_word(pidft_pkg::OP_ADD, SIDE_BASE, 2'd1, 8'hF0, 16'h7FFF, 8'h00);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic test_receiver_hold();
    hold_len = 100;
    repeat (12) send_random_word();
  endtask

  task automatic test_sender_pause();
    repeat (40) send_random_word();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (40) send_random_word();
  endtask

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    hold_len = 0;
    mismatches = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = pidft_pkg::OP_ADD;
    req_ch.side = SIDE_RELAY;
    req_ch.module_req = '0;
    req_ch.link_id = '0;
    req_ch.ident = '0;
    req_ch.peer = '0;
    for (int t = 0; t < NUM_TABLES; t++) shadow_fill[t] = 0;
    link_pool[0] = 8'h00;
    link_pool[1] = 8'hFF;
    for (int i = 2; i < 6; i++) link_pool[i] = 8'($urandom);
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_empty_tables();
    test_pairing();
    test_special_slots();
    test_table_full();
    test_random_traffic(700);
    test_receiver_hold();
    test_sender_pause();
    idle_on = 1'b0;
    test_random_traffic(180);

    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (ENTRIES + 4) @(negedge clk);
    if (mismatches == 0)
      $display("paired_id_forwarding_table_test: done, clean");
    else
      $display("paired_id_forwarding_table_test: done, errors");
    $finish;
  end

endmodule
